/* rtl/i2cms_pkg.sv */
// Shared types, status codes and action codes for the I2C master transaction sequencer.
`timescale 1ns / 1ps
package i2cms_pkg;

  typedef enum logic {
    KIND_CMD    = 1'b0,
    KIND_STATUS = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    OP_RD_STREAM = 2'd0,
    OP_WR_STREAM = 2'd1,
    OP_RD_REG    = 2'd2,
    OP_WR_REG    = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ACT_NONE  = 3'd0,
    ACT_START = 3'd1,
    ACT_SEND  = 3'd2,
    ACT_ACK   = 3'd3,
    ACT_NACK  = 3'd4,
    ACT_STOP  = 3'd5
  } action_e;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_START = 4'd1,
    PH_SLA   = 4'd2,
    PH_REG   = 4'd3,
    PH_RX    = 4'd4,
    PH_TX    = 4'd5
  } phase_e;

  localparam logic [7:0] STATUS_MASK = 8'hF8;
  localparam logic       RD_FLAG     = 1'b1;

  localparam logic [7:0] ST_START      = 8'h08;
  localparam logic [7:0] ST_RSTART     = 8'h10;
  localparam logic [7:0] ST_SLA_W_ACK  = 8'h18;
  localparam logic [7:0] ST_DATA_W_ACK = 8'h28;
  localparam logic [7:0] ST_SLA_R_ACK  = 8'h40;
  localparam logic [7:0] ST_DATA_R_ACK = 8'h50;
  localparam logic [7:0] ST_DATA_R_NAK = 8'h58;

  typedef struct packed {
    kind_e      kind;
    op_e        op;
    logic [6:0] target_addr;
    logic [7:0] reg_addr;
    logic [7:0] byte_count;
    logic [7:0] tx_byte;
    logic [7:0] bus_status;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    action_e    action;
    logic [7:0] action_byte;
    logic       rx_valid;
    logic [7:0] rx_data;
    logic       error_flag;
    logic [7:0] last_status;
    logic [7:0] bytes_done;
    logic [7:0] restarts;
    logic       closed;
  } out_item_t;

endpackage

/* rtl/i2cms_in_stage.sv */
// Input register stage: captures one item and holds it until the core consumes it.
`timescale 1ns / 1ps
module i2cms_in_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  i2cms_pkg::in_item_t in_item_i,
  output logic                valid_o,
  output i2cms_pkg::in_item_t item_o,
  input  logic                take_i
);
  import i2cms_pkg::*;

  logic     valid_q, valid_d;
  in_item_t item_q;
  logic     load;

  // hold while the stored item cannot move on
  assign in_stall_o = valid_q & ~take_i;
  assign load       = in_valid_i & ~in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

/* rtl/i2cms_core.sv */
// Transaction state and the per-item status check, next state and bus action decode.
`timescale 1ns / 1ps
module i2cms_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  i2cms_pkg::in_item_t  item_i,
  output i2cms_pkg::out_item_t result_o
);
  import i2cms_pkg::*;

  phase_e     phase_q, phase_d;
  op_e        cur_op_q, cur_op_d;
  logic [6:0] cur_target_q, cur_target_d;
  logic [7:0] cur_reg_q, cur_reg_d;
  logic [7:0] remaining_q, remaining_d;
  logic       err_q, err_d;
  logic [7:0] snapshot_q, snapshot_d;
  logic [7:0] transferred_q, transferred_d;
  logic [7:0] restart_q, restart_d;
  logic       done_q, done_d;
  logic       reading_q, reading_d;

  logic [7:0] code;
  logic [7:0] rem_dec;
  logic       rem_zero;
  logic       rem_many;
  logic       dec_zero;
  logic       dec_many;
  logic       ok;

  assign code     = item_i.bus_status & STATUS_MASK;
  assign rem_dec  = remaining_q - 8'd1;
  assign rem_zero = (remaining_q == 8'd0);
  assign rem_many = (remaining_q > 8'd1);
  assign dec_zero = (rem_dec == 8'd0);
  assign dec_many = (rem_dec > 8'd1);

  // status check against the code the current phase waits for
  always_comb begin
    case (phase_q)
      PH_START: ok = (code == ST_START) || (code == ST_RSTART);
      PH_SLA:   ok = (code == (reading_q ? ST_SLA_R_ACK : ST_SLA_W_ACK));
      PH_REG:   ok = (code == ST_DATA_W_ACK);
      PH_RX:    ok = (code == (rem_many ? ST_DATA_R_ACK : ST_DATA_R_NAK));
      PH_TX:    ok = (code == ST_DATA_W_ACK);
      default:  ok = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    phase_d       = phase_q;
    cur_op_d      = cur_op_q;
    cur_target_d  = cur_target_q;
    cur_reg_d     = cur_reg_q;
    remaining_d   = remaining_q;
    err_d         = err_q;
    snapshot_d    = snapshot_q;
    transferred_d = transferred_q;
    restart_d     = restart_q;
    done_d        = done_q;
    reading_d     = reading_q;
    if (item_i.kind == KIND_CMD) begin
      cur_op_d      = item_i.op;
      cur_target_d  = item_i.target_addr;
      cur_reg_d     = item_i.reg_addr;
      remaining_d   = item_i.byte_count;
      err_d         = 1'b0;
      transferred_d = 8'd0;
      done_d        = 1'b0;
      reading_d     = (item_i.op == OP_RD_STREAM);
      phase_d       = PH_START;
    end else if ((phase_q != PH_IDLE) && !ok) begin
      // abort without a stop
      err_d      = 1'b1;
      snapshot_d = item_i.bus_status;
      done_d     = 1'b0;
      phase_d    = PH_IDLE;
    end else begin
      case (phase_q)
        PH_START: begin
          restart_d = (code == ST_RSTART) ? restart_q + 8'd1 : 8'd0;
          phase_d   = PH_SLA;
        end
        PH_SLA: begin
          err_d         = 1'b0;
          snapshot_d    = item_i.bus_status;
          done_d        = 1'b0;
          transferred_d = 8'd0;
          if (cur_op_q[1] && !reading_q) begin
            phase_d = PH_REG;
          end else if (rem_zero) begin
            done_d  = 1'b1;
            phase_d = PH_IDLE;
          end else if (reading_q) begin
            phase_d = PH_RX;
          end else begin
            transferred_d = 8'd1;
            phase_d       = PH_TX;
          end
        end
        PH_REG: begin
          if (cur_op_q == OP_RD_REG) begin
            reading_d = 1'b1;
            phase_d   = PH_START;
          end else if (rem_zero) begin
            done_d  = 1'b1;
            phase_d = PH_IDLE;
          end else begin
            transferred_d = transferred_q + 8'd1;
            phase_d       = PH_TX;
          end
        end
        PH_RX: begin
          transferred_d = transferred_q + 8'd1;
          remaining_d   = rem_dec;
          if (dec_zero) begin
            done_d  = 1'b1;
            phase_d = PH_IDLE;
          end
        end
        PH_TX: begin
          remaining_d = rem_dec;
          if (dec_zero) begin
            done_d  = 1'b1;
            phase_d = PH_IDLE;
          end else begin
            transferred_d = transferred_q + 8'd1;
          end
        end
        default: phase_d = PH_IDLE;
      endcase
    end
  end

  // bus action and reported fields
  always_comb begin
    result_o             = '0;
    result_o.action      = ACT_NONE;
    result_o.error_flag  = err_d;
    result_o.last_status = snapshot_d;
    result_o.bytes_done  = transferred_d;
    result_o.restarts    = restart_d;
    result_o.closed      = done_d;
    if (item_i.kind == KIND_CMD) begin
      result_o.action = ACT_START;
    end else if (ok) begin
      case (phase_q)
        PH_START: begin
          result_o.action      = ACT_SEND;
          result_o.action_byte = {cur_target_q, reading_q & RD_FLAG};
        end
        PH_SLA: begin
          if (cur_op_q[1] && !reading_q) begin
            result_o.action      = ACT_SEND;
            result_o.action_byte = cur_reg_q;
          end else if (rem_zero) begin
            result_o.action = ACT_STOP;
          end else if (reading_q) begin
            result_o.action = rem_many ? ACT_ACK : ACT_NACK;
          end else begin
            result_o.action      = ACT_SEND;
            result_o.action_byte = item_i.tx_byte;
          end
        end
        PH_REG: begin
          if (cur_op_q == OP_RD_REG) begin
            result_o.action = ACT_START;
          end else if (rem_zero) begin
            result_o.action = ACT_STOP;
          end else begin
            result_o.action      = ACT_SEND;
            result_o.action_byte = item_i.tx_byte;
          end
        end
        PH_RX: begin
          result_o.rx_valid = 1'b1;
          result_o.rx_data  = item_i.rx_byte;
          if (dec_zero) begin
            result_o.action = ACT_STOP;
          end else begin
            result_o.action = dec_many ? ACT_ACK : ACT_NACK;
          end
        end
        PH_TX: begin
          if (dec_zero) begin
            result_o.action = ACT_STOP;
          end else begin
            result_o.action      = ACT_SEND;
            result_o.action_byte = item_i.tx_byte;
          end
        end
        default: result_o.action = ACT_NONE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_IDLE;
      cur_op_q      <= OP_RD_STREAM;
      cur_target_q  <= '0;
      cur_reg_q     <= '0;
      remaining_q   <= '0;
      err_q         <= 1'b0;
      snapshot_q    <= '0;
      transferred_q <= '0;
      restart_q     <= '0;
      done_q        <= 1'b0;
      reading_q     <= 1'b0;
    end else if (step_i) begin
      phase_q       <= phase_d;
      cur_op_q      <= cur_op_d;
      cur_target_q  <= cur_target_d;
      cur_reg_q     <= cur_reg_d;
      remaining_q   <= remaining_d;
      err_q         <= err_d;
      snapshot_q    <= snapshot_d;
      transferred_q <= transferred_d;
      restart_q     <= restart_d;
      done_q        <= done_d;
      reading_q     <= reading_d;
    end
  end

endmodule

/* rtl/i2cms_out_stage.sv */
// Result register stage: holds one result until the downstream side takes it.
`timescale 1ns / 1ps
module i2cms_out_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  i2cms_pkg::out_item_t result_i,
  output logic                 can_take_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output i2cms_pkg::out_item_t out_item_o
);
  import i2cms_pkg::*;

  logic      valid_q, valid_d;
  out_item_t item_q;

  // free when empty or when the held result leaves this cycle
  assign can_take_o = ~valid_q | ~out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      item_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule

/* rtl/i2c_master_transaction_sequencer.sv */
// An accepted item waits in the input register until the step that updates the state and loads its result.
// Throughput: one item per cycle; the input register, the state update and the
// result register all advance together whenever the result register is free.
// Stall on the input follows stall on the output in the same cycle.
// Reset: asynchronous, active low; both stages empty, phase idle, all counters zero.
`timescale 1ns / 1ps
module i2c_master_transaction_sequencer (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  i2cms_pkg::in_item_t  in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output i2cms_pkg::out_item_t out_item_o
);
  import i2cms_pkg::*;

  logic      stage_valid;
  in_item_t  stage_item;
  out_item_t result;
  logic      can_take;
  logic      step;

  assign step = stage_valid & can_take;

  i2cms_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .valid_o    (stage_valid),
    .item_o     (stage_item),
    .take_i     (step)
  );

  i2cms_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (stage_item),
    .result_o (result)
  );

  i2cms_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step),
    .result_i    (result),
    .can_take_o  (can_take),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

/* rtl/i2cms_checker.sv */
// Port-level checker for the I2C master transaction sequencer, bound to the top level.
`timescale 1ns / 1ps
module i2cms_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input i2cms_pkg::out_item_t out_item_o
);
  import i2cms_pkg::*;

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a stop only closes a clean transaction
  a_stop_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.action == ACT_STOP) |->
      out_item_o.closed && !out_item_o.error_flag)
    else $error("stop without clean close");

  // a received byte comes with the next receive or the stop
  a_rx_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.rx_valid |->
      (out_item_o.action == ACT_ACK) || (out_item_o.action == ACT_NACK) ||
      (out_item_o.action == ACT_STOP))
    else $error("received byte with wrong action");

  // byte field is only used for a send
  a_byte_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.action != ACT_SEND) |-> (out_item_o.action_byte == 8'd0))
    else $error("action byte set without send");

  // an empty pipeline after reset cannot hold off the input
  a_reset_ready: assert property (@(posedge clk_i)
    !rst_ni |=> !in_stall_o || !$past(rst_ni, 1) || in_valid_i || out_valid_o)
    else $error("input stalled straight after reset");

endmodule

bind i2c_master_transaction_sequencer i2cms_checker u_i2cms_checker (.*);
